// ----- rtl/core/zzr_pkg.sv -----
// ----------------------------------------------------------------------------
// zzr_pkg: shared types, constants and helper functions
// Geometry helpers for the zigzag scan walk and the job record that passes
// from the load side to the emit side.
// ----------------------------------------------------------------------------
package zzr_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_DIM     = 8;
  localparam int DIM_W       = 4;
  localparam int POS_W       = 3;   // row / column index
  localparam int DIAG_W      = 4;   // anti-diagonal index, row + column
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;   // position inside one block
  localparam int CNT_W       = 7;   // load count, holds the depth itself
  localparam int BANKS       = 2;
  localparam int BANK_W      = 1;
  localparam int MEM_AW      = ADDR_W + BANK_W;
  localparam int TRI_W       = 7;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_WIDTH  = 2'd0,
    CFG_BLOCK_HEIGHT = 2'd1,
    CFG_INVERSE_MODE = 2'd2
  } cfg_reg_e;

  // one complete block ready to be emitted
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic              inverse;
    logic [ADDR_W-1:0] last_idx;
    logic [BANK_W-1:0] bank;
  } job_t;

  // sample store write request
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  // zero counts as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = d;
    end
    return res;
  endfunction

  // first row touched by anti-diagonal d
  function automatic logic [POS_W-1:0] row_lo(input logic [DIAG_W-1:0] d,
                                              input logic [DIM_W-1:0] w);
    logic [DIAG_W:0] t;
    logic [POS_W-1:0] res;
    t = {1'b0, d} + (DIAG_W+1)'(1);
    if (t > (DIAG_W+1)'(w)) begin
      res = POS_W'(t - (DIAG_W+1)'(w));
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // last row touched by anti-diagonal d
  function automatic logic [POS_W-1:0] row_hi(input logic [DIAG_W-1:0] d,
                                              input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] hm1;
    logic [POS_W-1:0] res;
    hm1 = h - DIM_W'(1);
    if (DIM_W'(d) < hm1) begin
      res = POS_W'(d);
    end else begin
      res = POS_W'(hm1);
    end
    return res;
  endfunction

  // triangular number x*(x+1)/2
  function automatic logic [TRI_W-1:0] tri_num(input logic [DIAG_W-1:0] x);
    logic [TRI_W:0] p;
    p = (TRI_W+1)'(x) * ((TRI_W+1)'(x) + (TRI_W+1)'(1));
    return p[TRI_W:1];
  endfunction

  // number of samples on the anti-diagonals before d in a w x h block
  function automatic logic [TRI_W-1:0] zz_before(input logic [DIAG_W-1:0] d,
                                                 input logic [DIM_W-1:0]  w,
                                                 input logic [DIM_W-1:0]  h);
    logic [DIM_W:0]   wh;
    logic [TRI_W-1:0] t_w;
    logic [TRI_W-1:0] t_h;
    logic [TRI_W-1:0] t_wh;
    wh   = (DIM_W+1)'(w) + (DIM_W+1)'(h);
    t_w  = (DIM_W'(d) > w) ? tri_num(DIAG_W'(DIM_W'(d) - w)) : '0;
    t_h  = (DIM_W'(d) > h) ? tri_num(DIAG_W'(DIM_W'(d) - h)) : '0;
    t_wh = ((DIM_W+1)'(d) > wh) ? tri_num(DIAG_W'((DIM_W+1)'(d) - wh)) : '0;
    return tri_num(d) - t_w - t_h + t_wh;
  endfunction

endpackage

// ----- rtl/core/zzr_if.sv -----
// ----------------------------------------------------------------------------
// zzr_if: sample stream channels
// Valid/ready channels for incoming samples and reordered results.
// ----------------------------------------------------------------------------
interface zzr_in_if import zzr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface zzr_out_if import zzr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_sample;
  logic              out_last;

  modport source (output valid, output out_sample, output out_last, input ready);
  modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

// ----- rtl/core/zigzag_block_reorder_unit.sv -----
// Path: the first sample of a block passes the job queue and the registered
// store read after the block's last sample is accepted; the rest follow one per
// cycle while the output is ready. Throughput: one sample accepted per cycle
// while the job queue is not full and one emitted per cycle while the output is
// ready; with two store banks a block loads while the previous one drains, up to two blocks overlapped.
// Reset: load count, queue and output cleared; registers return to 8x8 forward.
// ----------------------------------------------------------------------------
// zigzag_block_reorder_unit: raster / zigzag block reorder
// Loads a block of up to 8x8 samples and emits it in zigzag or raster order.
// ----------------------------------------------------------------------------
module zigzag_block_reorder_unit import zzr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  zzr_in_if.sink                in_ch,
  zzr_out_if.source             out_ch
);

  mem_wr_t mem_wr;
  job_t    push_job;
  job_t    head;
  logic    push_valid;
  logic    q_full;
  logic    head_valid;
  logic    pop;

  // load side
  zzr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job),
    .mem_wr     (mem_wr)
  );

  // completed block queue
  zzr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // emit side
  zzr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_wr     (mem_wr),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/core/zzr_front.sv -----
// ----------------------------------------------------------------------------
// zzr_front: load side
// Holds the configuration, stores incoming samples into the current bank and
// posts a job once the block is complete.
// ----------------------------------------------------------------------------
module zzr_front import zzr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  zzr_in_if.sink                in_ch,
  input  logic                  q_full,
  output logic                  push_valid,
  output job_t                  push_job,
  output mem_wr_t               mem_wr
);

  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic              inverse_r;
  logic [CNT_W-1:0]  load_cnt_r;
  logic [CNT_W-1:0]  load_cnt_nxt;
  logic [BANK_W-1:0] bank_r;
  logic [BANK_W-1:0] bank_nxt;
  logic [DIM_W-1:0]  cw;
  logic [DIM_W-1:0]  ch;
  logic [CNT_W-1:0]  blk_size;
  logic [CNT_W-1:0]  cnt_inc;
  logic              accept;
  logic              done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(MAX_DIM);
      height_r  <= DIM_W'(MAX_DIM);
      inverse_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_BLOCK_WIDTH:  width_r   <= cfg_wdata[DIM_W-1:0];
        CFG_BLOCK_HEIGHT: height_r  <= cfg_wdata[DIM_W-1:0];
        CFG_INVERSE_MODE: inverse_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // block geometry
  assign cw       = clamp_dim(width_r);
  assign ch       = clamp_dim(height_r);
  assign blk_size = CNT_W'(CNT_W'(cw) * CNT_W'(ch));

  // accept while a bank is free
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_inc     = load_cnt_r + CNT_W'(1);
  assign done        = accept && (cnt_inc >= blk_size);

  // store write
  assign mem_wr.en   = accept;
  assign mem_wr.addr = {bank_r, load_cnt_r[ADDR_W-1:0]};
  assign mem_wr.data = in_ch.in_sample;

  // job for the emit side
  assign push_valid        = done;
  assign push_job.width    = cw;
  assign push_job.height   = ch;
  assign push_job.inverse  = inverse_r;
  assign push_job.last_idx = ADDR_W'(blk_size - CNT_W'(1));
  assign push_job.bank     = bank_r;

  // load count and bank select
  always_comb begin
    load_cnt_nxt = load_cnt_r;
    bank_nxt     = bank_r;
    if (done) begin
      load_cnt_nxt = '0;
      bank_nxt     = bank_r + BANK_W'(1);
    end else if (accept) begin
      load_cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      bank_r     <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      bank_r     <= bank_nxt;
    end
  end

endmodule

// ----- rtl/core/zzr_queue.sv -----
// ----------------------------------------------------------------------------
// zzr_queue: job queue
// Short FIFO of completed blocks between the load and emit sides.
// ----------------------------------------------------------------------------
module zzr_queue import zzr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic [QCNT_W-1:0] fill_nxt;

  assign full       = (fill_r == QCNT_W'(QDEPTH));
  assign head_valid = (fill_r != '0);
  assign head       = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // fill level
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QCNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// ----- rtl/core/zzr_back.sv -----
// ----------------------------------------------------------------------------
// zzr_back: emit side
// Two-bank sample store; walks the block in output order and reads one
// sample per cycle into the output register while it is free or draining.
// ----------------------------------------------------------------------------
module zzr_back import zzr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_wr_t  mem_wr,
  input  logic     head_valid,
  input  job_t     head,
  output logic     pop,
  zzr_out_if.source out_ch
);

  logic [DATA_W-1:0] mem [BANKS*STORE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              out_last_r;
  logic              out_valid_r;
  logic [POS_W-1:0]  row_r;
  logic [POS_W-1:0]  row_nxt;
  logic [POS_W-1:0]  col_r;
  logic [POS_W-1:0]  col_nxt;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] idx_nxt;
  logic              issue;
  logic              last;
  logic [DIAG_W-1:0] diag;
  logic [DIAG_W-1:0] diag_n;
  logic [POS_W-1:0]  rlo;
  logic [POS_W-1:0]  rhi;
  logic [POS_W-1:0]  zz_off;
  logic [ADDR_W-1:0] fwd_addr;
  logic [ADDR_W-1:0] inv_addr;
  logic [MEM_AW-1:0] rd_addr;

  // read when the output register is free or being drained
  assign issue = head_valid && (!out_valid_r || out_ch.ready);
  assign last  = (idx_r == head.last_idx);
  assign pop   = issue && last;

  // diagonal geometry of the current position
  assign diag   = DIAG_W'(row_r) + DIAG_W'(col_r);
  assign diag_n = diag + DIAG_W'(1);
  assign rlo    = row_lo(diag, head.width);
  assign rhi    = row_hi(diag, head.height);
  assign zz_off = diag[0] ? (row_r - rlo) : (rhi - row_r);

  // forward: raster address of the zigzag position
  assign fwd_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(head.width)) + ADDR_W'(col_r);
  // inverse: zigzag index of the raster position
  assign inv_addr = ADDR_W'(zz_before(diag, head.width, head.height) + TRI_W'(zz_off));
  assign rd_addr  = {head.bank, head.inverse ? inv_addr : fwd_addr};

  // sample store
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
  end

  // registered read doubles as the output register
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r  <= mem[rd_addr];
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = rd_data_r;
  assign out_ch.out_last   = out_last_r;

  // position walker: zigzag for forward, raster for inverse
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    idx_nxt = idx_r;
    if (pop) begin
      row_nxt = '0;
      col_nxt = '0;
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + ADDR_W'(1);
      if (head.inverse) begin
        if (DIM_W'(col_r) + DIM_W'(1) == head.width) begin
          col_nxt = '0;
          row_nxt = row_r + POS_W'(1);
        end else begin
          col_nxt = col_r + POS_W'(1);
        end
      end else if (!diag[0]) begin
        // even diagonal runs up-right
        if (row_r > rlo) begin
          row_nxt = row_r - POS_W'(1);
          col_nxt = col_r + POS_W'(1);
        end else begin
          row_nxt = row_lo(diag_n, head.width);
          col_nxt = POS_W'(diag_n - DIAG_W'(row_nxt));
        end
      end else begin
        // odd diagonal runs down-left
        if (row_r < rhi) begin
          row_nxt = row_r + POS_W'(1);
          col_nxt = col_r - POS_W'(1);
        end else begin
          row_nxt = row_hi(diag_n, head.height);
          col_nxt = POS_W'(diag_n - DIAG_W'(row_nxt));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      idx_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- tb/zzr_reorder_check.sv -----
// ----------------------------------------------------------------------------
// zzr_reorder_check: reorder predictor and result comparison
// Watches the register port and both sample channels. It keeps its own copy of
// the loaded samples and of the geometry, builds the reordered block when a
// block completes, and compares every emitted word with the oldest prediction.
// ----------------------------------------------------------------------------
module zzr_reorder_check import zzr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  zzr_in_if                     in_ch,
  zzr_out_if                    out_ch,
  output int                    fail_count,
  output int                    words_owed,
  output int                    blocks_done,
  output int                    words_matched
);

  typedef struct {
    logic [DATA_W-1:0] sample;
    logic              last;
  } zz_word_t;

  typedef int unsigned scan_t [STORE_DEPTH];

  // shadow of the block state
  logic [DATA_W-1:0] arrived [STORE_DEPTH];
  logic [CNT_W-1:0]  arrive_cnt;
  logic [DIM_W-1:0]  cols_cfg;
  logic [DIM_W-1:0]  rows_cfg;
  logic              inverse_cfg;
  zz_word_t          reordered_q [$];

  initial begin
    fail_count    = 0;
    words_owed    = 0;
    blocks_done   = 0;
    words_matched = 0;
    arrive_cnt    = '0;
    cols_cfg      = DIM_W'(MAX_DIM);
    rows_cfg      = DIM_W'(MAX_DIM);
    inverse_cfg   = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // usable dimension: zero means one, oversize means the maximum
  function automatic int unsigned usable_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  // raster index of each zigzag position, walking the block edge to edge
  function automatic scan_t zigzag_scan(input int unsigned cols, input int unsigned rows);
    scan_t       walk;
    int unsigned r;
    int unsigned c;
    int unsigned k;
    r = 0;
    c = 0;
    for (k = 0; k < STORE_DEPTH; k++) walk[k] = 0;
    for (k = 0; k < cols * rows; k++) begin
      walk[k] = r * cols + c;
      if (((r + c) % 2) == 0) begin
        // heading up and to the right
        if (c == cols - 1) r++;
        else if (r == 0) c++;
        else begin
          r--;
          c++;
        end
      end else begin
        // heading down and to the left
        if (r == rows - 1) c++;
        else if (c == 0) r++;
        else begin
          r++;
          c--;
        end
      end
    end
    return walk;
  endfunction

  // queue the whole reordered block under the current geometry and direction
  task automatic complete_block();
    int unsigned       cols;
    int unsigned       rows;
    int unsigned       size;
    int unsigned       k;
    scan_t             walk;
    logic [DATA_W-1:0] block [STORE_DEPTH];
    zz_word_t          word;
    cols = usable_dim(cols_cfg);
    rows = usable_dim(rows_cfg);
    size = cols * rows;
    walk = zigzag_scan(cols, rows);
    for (k = 0; k < size; k++) begin
      if (inverse_cfg) block[walk[k]] = arrived[k];
      else block[k] = arrived[walk[k]];
    end
    for (k = 0; k < size; k++) begin
      word.sample = block[k];
      word.last   = (k == size - 1);
      reordered_q.push_back(word);
    end
    blocks_done++;
  endtask

  always @(posedge clk) begin : watch
    zz_word_t    want;
    int unsigned size;
    if (!rst_n) begin
      arrive_cnt  = '0;
      cols_cfg    = DIM_W'(MAX_DIM);
      rows_cfg    = DIM_W'(MAX_DIM);
      inverse_cfg = 1'b0;
      reordered_q.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_reg_e'(cfg_index))
          CFG_BLOCK_WIDTH:  cols_cfg = cfg_wdata;
          CFG_BLOCK_HEIGHT: rows_cfg = cfg_wdata;
          CFG_INVERSE_MODE: inverse_cfg = cfg_wdata[0];
          default: ;
        endcase
      end
      // emitted words against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (reordered_q.size() == 0) begin
          report_mismatch($sformatf("word %h last %b with nothing predicted",
                                    out_ch.out_sample, out_ch.out_last));
        end else begin
          want = reordered_q.pop_front();
          if (out_ch.out_sample !== want.sample) begin
            report_mismatch($sformatf("out_sample got %h want %h",
                                      out_ch.out_sample, want.sample));
          end else if (out_ch.out_last !== want.last) begin
            report_mismatch($sformatf("out_last got %b want %b on word %h",
                                      out_ch.out_last, want.last, want.sample));
          end else begin
            words_matched++;
          end
        end
      end
      // accepted sample request
      if (in_ch.valid && in_ch.ready) begin
        arrived[arrive_cnt[ADDR_W-1:0]] = in_ch.in_sample;
        arrive_cnt = arrive_cnt + CNT_W'(1);
        size = usable_dim(cols_cfg) * usable_dim(rows_cfg);
        if (int'(arrive_cnt) >= size) begin
          arrive_cnt = '0;
          complete_block();
        end
      end
    end
    words_owed = reordered_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: zigzag block reorder testbench
// Drives sample requests and register writes into the reorder unit, stalls
// the output side at random, and leaves prediction and comparison to the
// checker beside it. Directed blocks come first, then random geometries.
// ----------------------------------------------------------------------------
module tb import zzr_pkg::*; ();

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int WORD_TARGET   = 215;
  localparam int CALM_TAIL     = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  cfg_reg_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  zzr_in_if  in_ch ();
  zzr_out_if out_ch ();

  int fail_count;
  int words_owed;
  int blocks_done;
  int words_matched;

  int unsigned words_sent;
  int unsigned in_block;
  int unsigned cur_size;
  int unsigned settings_used;
  int unsigned cycle_count;
  int unsigned tx_stretch;
  bit          tx_calm;
  bit          gaps_on;
  bit          hold_off_req;

  zigzag_block_reorder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  zzr_reorder_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_owed    (words_owed),
    .blocks_done   (blocks_done),
    .words_matched (words_matched)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d words outstanding", words_owed);
      $display("FAIL zigzag_block_reorder_unit");
      $finish;
    end
  end

  // result side: random stall bursts, calm stretches and one long hold-off
  initial begin : result_side
    int unsigned rx_stretch;
    bit          rx_calm;
    rx_stretch   = 0;
    rx_calm      = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(10, 40);
        rx_calm    = ($urandom_range(0, 2) == 0);
      end
      rx_stretch--;
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (gaps_on && !rx_calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic int unsigned block_words(input logic [DIM_W-1:0] w,
                                              input logic [DIM_W-1:0] h);
    int unsigned cw;
    int unsigned ch;
    cw = (w == '0) ? 1 : (w > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(w);
    ch = (h == '0) ? 1 : (h > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(h);
    return cw * ch;
  endfunction

  // sample word with extra weight on all zeros and all ones
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // one sample request, held until taken; returns at a falling edge
  task automatic send_word(input logic [DATA_W-1:0] word);
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(10, 40);
      tx_calm    = ($urandom_range(0, 2) == 0);
    end
    tx_stretch--;
    if (gaps_on && !tx_calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.in_sample = word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // hold requests until every predicted word is out and the unit has settled
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] mode_word);
    wait_idle();
    write_reg(CFG_BLOCK_WIDTH, w);
    write_reg(CFG_BLOCK_HEIGHT, h);
    write_reg(CFG_INVERSE_MODE, mode_word);
    cur_size = block_words(w, h);
    settings_used++;
  endtask

  // finish the open block and then whole blocks, with random content
  task automatic fill_blocks(input int unsigned nblocks);
    int unsigned need;
    repeat (nblocks) begin
      need = (in_block >= cur_size) ? 1 : cur_size - in_block;
      repeat (need) send_word(pick_word());
      in_block = 0;
    end
  endtask

  // part of a block, left open so the next geometry finishes it
  task automatic fill_partial(input int unsigned count);
    repeat (count) send_word(pick_word());
    in_block += count;
  endtask

  initial begin : stimulus
    int unsigned i;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_BLOCK_WIDTH;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.in_sample = '0;
    words_sent      = 0;
    in_block        = 0;
    cur_size        = MAX_DIM * MAX_DIM;
    settings_used   = 0;
    tx_stretch      = 0;
    tx_calm         = 1'b1;
    gaps_on         = 1'b1;
    hold_off_req    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero dimensions act as a single sample, extremes of the data
    load_geometry(4'd0, 4'd0, 4'd0);
    send_word('0);
    send_word('1);
    // small zigzag-to-raster block
    load_geometry(4'd3, 4'd2, 4'd1);
    for (i = 1; i <= 6; i++) send_word(32'h1111_1111 * i);
    // oversize width clamps to the maximum, single row
    load_geometry(4'd15, 4'd1, 4'd0);
    for (i = 0; i < 8; i++) send_word(32'hA5A5_0000 + i);
    // geometry shrinks below the words already loaded
    load_geometry(4'd2, 4'd3, 4'd0);
    fill_partial(4);
    load_geometry(4'd1, 4'd2, 4'b1110);
    fill_blocks(1);
    // geometry changes with a block half loaded
    load_geometry(4'd2, 4'd2, 4'd0);
    fill_partial(2);
    load_geometry(4'd3, 4'd1, 4'b1111);
    fill_blocks(1);

    // full size block in the inverse direction
    load_geometry(4'd8, 4'd8, 4'd1);
    fill_blocks(1);
    // output held off while requests keep coming, so the input backs up
    load_geometry(4'd2, 4'd3, 4'd0);
    hold_off_req = 1'b1;
    fill_blocks(10);

    // random geometries, mostly small, sometimes left open across a change
    while (words_sent < WORD_TARGET) begin
      if (words_sent + CALM_TAIL >= WORD_TARGET) gaps_on = 1'b0;
      w = ($urandom_range(0, 6) == 0) ? DIM_W'($urandom_range(0, 15))
                                      : DIM_W'($urandom_range(0, 4));
      h = ($urandom_range(0, 6) == 0) ? DIM_W'($urandom_range(0, 15))
                                      : DIM_W'($urandom_range(0, 4));
      load_geometry(w, h, CFG_DATA_W'($urandom_range(0, 15)));
      if (in_block == 0 && cur_size > 1 && $urandom_range(0, 3) == 0) begin
        fill_partial($urandom_range(1, cur_size - 1));
      end else begin
        fill_blocks($urandom_range(1, 3));
      end
    end

    // drain and let the unit settle
    in_ch.valid = 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d samples in %0d register settings; %0d blocks, %0d words matched",
             words_sent, settings_used, blocks_done, words_matched);
    $display("both scan directions, clamped sizes, mid-block geometry changes, output hold-off");
    if (fail_count == 0) begin
      $display("PASS zigzag_block_reorder_unit");
    end else begin
      $display("FAIL zigzag_block_reorder_unit");
    end
    $finish;
  end

endmodule
